FILE: sv/lefs_pkg.sv
// ----------------------------------------------------------------------------
// lefs_pkg
// Shared types, constants and saturating helpers for the exchange-field
// stencil block.
// ----------------------------------------------------------------------------
package lefs_pkg;

    localparam int DATA_W     = 32;
    localparam int IDX_W      = 14;
    localparam int ACC_W      = 64;
    localparam int LIN_W      = 17;
    localparam int SUM_W      = 36;
    localparam int TDATA_W    = 176;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;
    localparam int DIV_STEPS  = 64;
    localparam int DIV_CNT_W  = 6;
    localparam int QLIM_W     = 12;
    localparam int INV_W      = 28;

    // round(256 / mu0)
    localparam logic [INV_W-1:0] INV_MU0_Q8 = 28'd203718327;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X = 3'd0,
        CFG_SIZE_Y = 3'd1,
        CFG_SIZE_Z = 3'd2,
        CFG_WRAP_X = 3'd3,
        CFG_WRAP_Y = 3'd4,
        CFG_WRAP_Z = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        DIR_XM   = 3'd0,
        DIR_XP   = 3'd1,
        DIR_YM   = 3'd2,
        DIR_YP   = 3'd3,
        DIR_ZM   = 3'd4,
        DIR_ZP   = 3'd5,
        DIR_DONE = 3'd6
    } dir_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CHECK,
        ST_CENTER,
        ST_DIV_Z,
        ST_DIV_Y,
        ST_NB_ADDR,
        ST_NB_DATA,
        ST_NB_START,
        ST_NB_DIV,
        ST_F_MUL_P,
        ST_F_START_P,
        ST_F_DIV_P,
        ST_F_MUL_Q,
        ST_F_MUL_R,
        ST_F_START_R,
        ST_F_DIV_R,
        ST_F_SAT,
        ST_F_DOT,
        ST_F_ACC,
        ST_ENERGY,
        ST_EMIT
    } state_t;

    // one lattice cell, moment in the lowest bits
    typedef struct packed {
        logic [DATA_W-1:0] mag_z;
        logic [DATA_W-1:0] mag_y;
        logic [DATA_W-1:0] mag_x;
        logic [DATA_W-1:0] coupling;
        logic [DATA_W-1:0] moment;
    } cell_t;

    typedef struct packed {
        logic              start;
        logic [63:0]       dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [63:0]       quot;
        logic [DATA_W-1:0] rem;
    } div_rsp_t;

    function automatic logic [ACC_W-1:0] sat_add64(input logic [ACC_W-1:0] a,
                                                   input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        return s[ACC_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] sat32(input logic [SUM_W-1:0] v);
        if (v[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){v[DATA_W-1]}})
            return v[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return v[DATA_W-1:0];
    endfunction

    // sign and magnitude to saturated signed 32 bits
    function automatic logic [DATA_W-1:0] sat_signed_mag(input logic neg,
                                                         input logic [63:0] mag);
        if (neg) begin
            if (mag[63:32] != '0 || (mag[31] && mag[30:0] != '0))
                return 32'h8000_0000;
            return 32'(0) - mag[31:0];
        end
        if (mag[63:31] != '0)
            return 32'h7FFF_FFFF;
        return mag[31:0];
    endfunction

endpackage

FILE: sv/lattice_exchange_field_stencil.sv
// ----------------------------------------------------------------------------
// lattice_exchange_field_stencil
// Load: store write and energy clear; the next transaction can
// follow at once. Compute time is set by the bit-serial divider, used twice
// per cell, three times per neighbour with nonzero moment and up to six times
// for the field; empty or outside cells skip the divisions.
// Reset clears the control state, the wrap registers and the energy sum and
// sets the size registers to 32, 32 and 16; the cell store is not cleared.
// ----------------------------------------------------------------------------
module lattice_exchange_field_stencil #(
    parameter int MAX_X     = 32,
    parameter int MAX_Y     = 32,
    parameter int MAX_Z     = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // cell_index, moment_in, coupling_in, mag_x_in, mag_y_in, mag_z_in, pad
    input  logic [lefs_pkg::TDATA_W-1:0]       s_tdata,
    // req_type
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_index, field_x, field_y, field_z, energy_sum, pad
    output logic [lefs_pkg::TDATA_W-1:0]       m_tdata,
    input  logic                               cfg_we,
    input  logic [lefs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lefs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CELLS  = MAX_X * MAX_Y * MAX_Z;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int LW     = (ADDR_W > lefs_pkg::LIN_W) ? ADDR_W : lefs_pkg::LIN_W;

    // configuration
    logic [5:0] size_x_reg, size_y_reg;
    logic [4:0] size_z_reg;
    logic       wrap_x_reg, wrap_y_reg, wrap_z_reg;
    logic [5:0] sx, sy;
    logic [4:0] sz;

    lefs_pkg::state_t state_reg, state_next;

    logic                           acc_in;
    logic [lefs_pkg::IDX_W-1:0]     in_idx;
    lefs_pkg::cell_t                in_cell;
    logic [LW-1:0]                  in_lin;

    logic                           mem_we, mem_en, rd_en;
    logic [LW-1:0]                  rd_lin;
    logic [ADDR_W-1:0]              mem_addr;
    lefs_pkg::cell_t                mem_rdata;

    lefs_pkg::div_req_t             div_req;
    lefs_pkg::div_rsp_t             div_rsp;

    // per-item registers
    logic [lefs_pkg::IDX_W-1:0]     idx_reg;
    logic [11:0]                    sxy_reg, spy_reg;
    logic [lefs_pkg::LIN_W-1:0]     total_reg, spz_reg;
    logic [31:0]                    mu_reg, j_reg;
    logic [31:0]                    m_reg [3];
    logic [5:0]                     x_reg, y_reg;
    logic [4:0]                     z_reg;
    lefs_pkg::dir_t                 nb_reg;
    logic [1:0]                     comp_reg;
    logic [31:0]                    nmu_reg;
    logic [31:0]                    nmag_reg [3];
    logic [lefs_pkg::SUM_W-1:0]     acc_reg [3];
    logic [31:0]                    h_reg [3];
    logic                           neg_reg;
    logic [63:0]                    qk_reg, hmag_reg, mul_reg, dot_reg;
    logic [lefs_pkg::ACC_W-1:0]     energy_reg;
    logic                           out_valid_reg;
    logic [lefs_pkg::TDATA_W-1:0]   out_data_reg;

    logic                           nb_ok;
    logic [LW-1:0]                  nb_lin;
    logic [LW-1:0]                  lin_idx, lin_x, lin_sx, lin_sxy, lin_spy, lin_spz;
    lefs_pkg::dir_t                 nb_step;
    logic signed [32:0]             mul_a, mul_b;
    logic signed [65:0]             mul_p;
    logic [32:0]                    nmag_abs;
    logic [63:0]                    p_abs;
    logic [31:0]                    term;
    logic [31:0]                    s_k;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= 6'd32;
            size_y_reg <= 6'd32;
            size_z_reg <= 5'd16;
            wrap_x_reg <= 1'b0;
            wrap_y_reg <= 1'b0;
            wrap_z_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (lefs_pkg::cfg_reg_t'(cfg_index))
                lefs_pkg::CFG_SIZE_X: size_x_reg <= cfg_data;
                lefs_pkg::CFG_SIZE_Y: size_y_reg <= cfg_data;
                lefs_pkg::CFG_SIZE_Z: size_z_reg <= cfg_data[4:0];
                lefs_pkg::CFG_WRAP_X: wrap_x_reg <= cfg_data[0];
                lefs_pkg::CFG_WRAP_Y: wrap_y_reg <= cfg_data[0];
                lefs_pkg::CFG_WRAP_Z: wrap_z_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // zero means one, above the lattice maximum means the maximum
    always_comb
    begin
        if (size_x_reg == '0)
            sx = 6'd1;
        else if (32'(size_x_reg) > MAX_X)
            sx = 6'(MAX_X);
        else
            sx = size_x_reg;
        if (size_y_reg == '0)
            sy = 6'd1;
        else if (32'(size_y_reg) > MAX_Y)
            sy = 6'(MAX_Y);
        else
            sy = size_y_reg;
        if (size_z_reg == '0)
            sz = 5'd1;
        else if (32'(size_z_reg) > MAX_Z)
            sz = 5'(MAX_Z);
        else
            sz = size_z_reg;
    end

    // ---------------------------------------------------------------- input
    assign s_tready = (state_reg == lefs_pkg::ST_IDLE);
    assign acc_in   = s_tvalid && s_tready;
    assign in_idx   = s_tdata[13:0];
    assign in_cell  = lefs_pkg::cell_t'(s_tdata[173:14]);
    assign in_lin   = LW'(in_idx);

    assign mem_we   = acc_in && !s_tuser && (32'(in_idx) < CELLS);
    assign mem_en   = mem_we || rd_en;
    assign mem_addr = (state_reg == lefs_pkg::ST_IDLE) ? in_lin[ADDR_W-1:0]
                                                       : rd_lin[ADDR_W-1:0];

    lefs_mem #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (in_cell),
        .rdata (mem_rdata)
    );

    lefs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------ neighbours
    assign lin_idx = LW'(idx_reg);
    assign lin_x   = LW'(x_reg);
    assign lin_sx  = LW'(sx);
    assign lin_sxy = LW'(sxy_reg);
    assign lin_spy = LW'(spy_reg);
    assign lin_spz = LW'(spz_reg);
    assign nb_step = lefs_pkg::dir_t'(nb_reg + 3'd1);

    always_comb
    begin
        nb_ok  = 1'b0;
        nb_lin = '0;
        case (nb_reg)
            lefs_pkg::DIR_XM:
            begin
                nb_ok  = (x_reg != '0) || wrap_x_reg;
                nb_lin = (x_reg != '0) ? lin_idx - LW'(1)
                                       : lin_idx - lin_x + lin_sx - LW'(1);
            end
            lefs_pkg::DIR_XP:
            begin
                nb_ok  = ({1'b0, x_reg} + 7'd1 < {1'b0, sx}) || wrap_x_reg;
                nb_lin = ({1'b0, x_reg} + 7'd1 < {1'b0, sx}) ? lin_idx + LW'(1)
                                                              : lin_idx - lin_x;
            end
            lefs_pkg::DIR_YM:
            begin
                nb_ok  = (y_reg != '0) || wrap_y_reg;
                nb_lin = (y_reg != '0) ? lin_idx - lin_sx : lin_idx + lin_spy;
            end
            lefs_pkg::DIR_YP:
            begin
                nb_ok  = ({1'b0, y_reg} + 7'd1 < {1'b0, sy}) || wrap_y_reg;
                nb_lin = ({1'b0, y_reg} + 7'd1 < {1'b0, sy}) ? lin_idx + lin_sx
                                                              : lin_idx - lin_spy;
            end
            lefs_pkg::DIR_ZM:
            begin
                nb_ok  = (z_reg != '0) || wrap_z_reg;
                nb_lin = (z_reg != '0) ? lin_idx - lin_sxy : lin_idx + lin_spz;
            end
            lefs_pkg::DIR_ZP:
            begin
                nb_ok  = ({1'b0, z_reg} + 6'd1 < {1'b0, sz}) || wrap_z_reg;
                nb_lin = ({1'b0, z_reg} + 6'd1 < {1'b0, sz}) ? lin_idx + lin_sxy
                                                              : lin_idx - lin_spz;
            end
            default: ;
        endcase
    end

    // ----------------------------------------------------- shared multiplier
    assign s_k = lefs_pkg::sat32(acc_reg[comp_reg]);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            lefs_pkg::ST_F_MUL_P:
            begin
                mul_a = {j_reg[31], j_reg};
                mul_b = {s_k[31], s_k};
            end
            lefs_pkg::ST_F_MUL_Q:
            begin
                mul_a = 33'({div_rsp.quot[lefs_pkg::QLIM_W-1:0]});
                mul_b = 33'(lefs_pkg::INV_MU0_Q8);
            end
            lefs_pkg::ST_F_MUL_R:
            begin
                mul_a = {1'b0, div_rsp.rem};
                mul_b = 33'(lefs_pkg::INV_MU0_Q8);
            end
            lefs_pkg::ST_F_DOT:
            begin
                mul_a = {m_reg[comp_reg][31], m_reg[comp_reg]};
                mul_b = {h_reg[comp_reg][31], h_reg[comp_reg]};
            end
            default: ;
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign nmag_abs = nmag_reg[comp_reg][31] ? 33'(0) - {1'b1, nmag_reg[comp_reg]}
                                             : {1'b0, nmag_reg[comp_reg]};
    assign p_abs    = mul_reg[63] ? 64'(0) - mul_reg : mul_reg;
    assign term     = lefs_pkg::sat_signed_mag(nmag_reg[comp_reg][31], div_rsp.quot);

    // --------------------------------------------------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lefs_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        div_req    = '0;
        rd_en      = 1'b0;
        rd_lin     = '0;
        unique case (state_reg)
            lefs_pkg::ST_IDLE:
                if (acc_in && s_tuser)
                    state_next = lefs_pkg::ST_SETUP;
            lefs_pkg::ST_SETUP:
                state_next = lefs_pkg::ST_CHECK;
            lefs_pkg::ST_CHECK:
                if (lefs_pkg::LIN_W'(idx_reg) < total_reg)
                begin
                    rd_en      = 1'b1;
                    rd_lin     = lin_idx;
                    state_next = lefs_pkg::ST_CENTER;
                end
                else
                    state_next = lefs_pkg::ST_EMIT;
            lefs_pkg::ST_CENTER:
                if (mem_rdata.moment == '0)
                    state_next = lefs_pkg::ST_EMIT;
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = 64'(idx_reg);
                    div_req.divisor  = 32'(sxy_reg);
                    state_next       = lefs_pkg::ST_DIV_Z;
                end
            lefs_pkg::ST_DIV_Z:
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = 64'(div_rsp.rem);
                    div_req.divisor  = 32'(sx);
                    state_next       = lefs_pkg::ST_DIV_Y;
                end
            lefs_pkg::ST_DIV_Y:
                if (div_rsp.done)
                    state_next = lefs_pkg::ST_NB_ADDR;
            lefs_pkg::ST_NB_ADDR:
                if (nb_reg == lefs_pkg::DIR_DONE)
                    state_next = lefs_pkg::ST_F_MUL_P;
                else if (nb_ok)
                begin
                    rd_en      = 1'b1;
                    rd_lin     = nb_lin;
                    state_next = lefs_pkg::ST_NB_DATA;
                end
            lefs_pkg::ST_NB_DATA:
                state_next = (mem_rdata.moment == '0) ? lefs_pkg::ST_NB_ADDR
                                                      : lefs_pkg::ST_NB_START;
            lefs_pkg::ST_NB_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = 64'(nmag_abs) << FRAC_BITS;
                div_req.divisor  = nmu_reg;
                state_next       = lefs_pkg::ST_NB_DIV;
            end
            lefs_pkg::ST_NB_DIV:
                if (div_rsp.done)
                    state_next = (comp_reg == 2'd2) ? lefs_pkg::ST_NB_ADDR
                                                    : lefs_pkg::ST_NB_START;
            lefs_pkg::ST_F_MUL_P:
                state_next = lefs_pkg::ST_F_START_P;
            lefs_pkg::ST_F_START_P:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = p_abs;
                div_req.divisor  = mu_reg;
                state_next       = lefs_pkg::ST_F_DIV_P;
            end
            lefs_pkg::ST_F_DIV_P:
                if (div_rsp.done)
                    state_next = (div_rsp.quot[63:lefs_pkg::QLIM_W] != '0)
                                 ? lefs_pkg::ST_F_SAT : lefs_pkg::ST_F_MUL_Q;
            lefs_pkg::ST_F_MUL_Q:
                state_next = lefs_pkg::ST_F_MUL_R;
            lefs_pkg::ST_F_MUL_R:
                state_next = lefs_pkg::ST_F_START_R;
            lefs_pkg::ST_F_START_R:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = mul_reg;
                div_req.divisor  = mu_reg;
                state_next       = lefs_pkg::ST_F_DIV_R;
            end
            lefs_pkg::ST_F_DIV_R:
                if (div_rsp.done)
                    state_next = lefs_pkg::ST_F_SAT;
            lefs_pkg::ST_F_SAT:
                state_next = lefs_pkg::ST_F_DOT;
            lefs_pkg::ST_F_DOT:
                state_next = lefs_pkg::ST_F_ACC;
            lefs_pkg::ST_F_ACC:
                state_next = (comp_reg == 2'd2) ? lefs_pkg::ST_ENERGY
                                                : lefs_pkg::ST_F_MUL_P;
            lefs_pkg::ST_ENERGY:
                state_next = lefs_pkg::ST_EMIT;
            lefs_pkg::ST_EMIT:
                if (!out_valid_reg || m_tready)
                    state_next = lefs_pkg::ST_IDLE;
            default:
                state_next = lefs_pkg::ST_IDLE;
        endcase
    end

    // ----------------------------------------------------------- datapath
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_p[63:0];
        case (state_reg)
            lefs_pkg::ST_IDLE:
                if (acc_in)
                begin
                    idx_reg  <= in_idx;
                    sxy_reg  <= 12'(sx * sy);
                    spy_reg  <= 12'((sy - 6'd1) * sx);
                    dot_reg  <= '0;
                    for (int k = 0; k < 3; k++)
                    begin
                        h_reg[k]   <= '0;
                        acc_reg[k] <= '0;
                    end
                end
            lefs_pkg::ST_SETUP:
            begin
                total_reg <= lefs_pkg::LIN_W'(sxy_reg * sz);
                spz_reg   <= lefs_pkg::LIN_W'(sxy_reg * (sz - 5'd1));
            end
            lefs_pkg::ST_CENTER:
            begin
                mu_reg   <= mem_rdata.moment;
                j_reg    <= mem_rdata.coupling;
                m_reg[0] <= mem_rdata.mag_x;
                m_reg[1] <= mem_rdata.mag_y;
                m_reg[2] <= mem_rdata.mag_z;
            end
            lefs_pkg::ST_DIV_Z:
                if (div_rsp.done)
                    z_reg <= div_rsp.quot[4:0];
            lefs_pkg::ST_DIV_Y:
                if (div_rsp.done)
                begin
                    y_reg  <= div_rsp.quot[5:0];
                    x_reg  <= div_rsp.rem[5:0];
                    nb_reg <= lefs_pkg::DIR_XM;
                end
            lefs_pkg::ST_NB_ADDR:
            begin
                comp_reg <= '0;
                if (nb_reg != lefs_pkg::DIR_DONE && !nb_ok)
                    nb_reg <= nb_step;
            end
            lefs_pkg::ST_NB_DATA:
            begin
                nmu_reg     <= mem_rdata.moment;
                nmag_reg[0] <= mem_rdata.mag_x;
                nmag_reg[1] <= mem_rdata.mag_y;
                nmag_reg[2] <= mem_rdata.mag_z;
                comp_reg    <= '0;
                // empty neighbour contributes nothing
                if (mem_rdata.moment == '0)
                    nb_reg <= nb_step;
            end
            lefs_pkg::ST_NB_DIV:
                if (div_rsp.done)
                begin
                    acc_reg[comp_reg] <= acc_reg[comp_reg]
                                         + {{(lefs_pkg::SUM_W-32){term[31]}}, term};
                    if (comp_reg == 2'd2)
                    begin
                        nb_reg   <= nb_step;
                        comp_reg <= '0;
                    end
                    else
                        comp_reg <= comp_reg + 2'd1;
                end
            lefs_pkg::ST_F_START_P:
                neg_reg <= mul_reg[63];
            lefs_pkg::ST_F_DIV_P:
                // quotient too large saturates the field in any case
                if (div_rsp.done && div_rsp.quot[63:lefs_pkg::QLIM_W] != '0)
                    hmag_reg <= 64'h1_0000_0000;
            lefs_pkg::ST_F_MUL_R:
                qk_reg <= mul_reg;
            lefs_pkg::ST_F_DIV_R:
                if (div_rsp.done)
                    hmag_reg <= (qk_reg + div_rsp.quot) >> 8;
            lefs_pkg::ST_F_SAT:
                h_reg[comp_reg] <= lefs_pkg::sat_signed_mag(neg_reg, hmag_reg);
            lefs_pkg::ST_F_ACC:
            begin
                dot_reg <= lefs_pkg::sat_add64(dot_reg, mul_reg);
                if (comp_reg != 2'd2)
                    comp_reg <= comp_reg + 2'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            energy_reg <= '0;
        else if (acc_in && !s_tuser)
            energy_reg <= '0;
        else if (state_reg == lefs_pkg::ST_ENERGY)
            energy_reg <= lefs_pkg::sat_add64(energy_reg, dot_reg);
    end

    // ------------------------------------------------------------- output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == lefs_pkg::ST_EMIT && (!out_valid_reg || m_tready))
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == lefs_pkg::ST_EMIT && (!out_valid_reg || m_tready))
            out_data_reg <= {2'b00, energy_reg, h_reg[2], h_reg[1], h_reg[0], idx_reg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: sv/lefs_mem.sv
// ----------------------------------------------------------------------------
// lefs_mem
// Single-port cell store, one cell record per entry, registered read data.
// ----------------------------------------------------------------------------
module lefs_mem #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     addr,
    input  lefs_pkg::cell_t       wdata,
    output lefs_pkg::cell_t       rdata
);

    lefs_pkg::cell_t mem [DEPTH];
    lefs_pkg::cell_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/lefs_div.sv
// ----------------------------------------------------------------------------
// lefs_div
// Shared restoring divider, 64-bit dividend by 32-bit divisor, one quotient
// bit per cycle while busy.
// ----------------------------------------------------------------------------
module lefs_div (
    input  logic                clk,
    input  logic                rst_n,
    input  lefs_pkg::div_req_t  req,
    output lefs_pkg::div_rsp_t  rsp
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [lefs_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [63:0]                     dvd_reg;
    logic [lefs_pkg::DATA_W-1:0]     rem_reg;
    logic [lefs_pkg::DATA_W-1:0]     dvs_reg;
    logic [lefs_pkg::DATA_W:0]       trial;
    logic                            fits;

    assign trial = {rem_reg, dvd_reg[63]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == lefs_pkg::DIV_CNT_W'(lefs_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in behind the dividend bits
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[62:0], fits};
            rem_reg <= fits ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
        end
    end

    assign rsp = {done_reg, dvd_reg, rem_reg};

endmodule

FILE: verif/lattice_exchange_field_stencil_checker.sv
// ----------------------------------------------------------------------------
// lattice_exchange_field_stencil_checker
// Watches the request, result and register ports of the stencil block, keeps
// its own copy of the cell stores and the energy sum, predicts every result
// and compares it field by field in order of arrival.
// ----------------------------------------------------------------------------
module lattice_exchange_field_stencil_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [lefs_pkg::TDATA_W-1:0]    s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [lefs_pkg::TDATA_W-1:0]    m_tdata,
    input  logic                            cfg_we,
    input  logic [lefs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lefs_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              errors,
    output int                              pending,
    output int                              results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCELLS = 16384;
    localparam longint unsigned INV_MU0 = 64'd203718327;
    localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [lefs_pkg::IDX_W-1:0] idx;
        logic [31:0]                hx;
        logic [31:0]                hy;
        logic [31:0]                hz;
        logic [63:0]                energy;
    } field_result_t;

    logic [31:0] moment_mem   [NCELLS];
    logic [31:0] coupling_mem [NCELLS];
    logic [31:0] magx_mem     [NCELLS];
    logic [31:0] magy_mem     [NCELLS];
    logic [31:0] magz_mem     [NCELLS];
    longint      energy;
    logic [5:0]  size_x, size_y;
    logic [4:0]  size_z;
    logic        wrap_x, wrap_y, wrap_z;
    longint      nb_sum [3];
    field_result_t field_q [$];

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint add_sat64(longint a, longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? S64_MIN : S64_MAX;
        return s;
    endfunction

    function automatic int unsigned clamp_size(int unsigned v, int unsigned mx);
        if (v == 0)
            return 1;
        return (v > mx) ? mx : v;
    endfunction

    function automatic void add_neighbor(int unsigned n);
        longint mu;
        mu = longint'(moment_mem[n]);
        if (mu == 0)
            return;
        nb_sum[0] += clip32((longint'(signed'(magx_mem[n])) * 65536) / mu);
        nb_sum[1] += clip32((longint'(signed'(magy_mem[n])) * 65536) / mu);
        nb_sum[2] += clip32((longint'(signed'(magz_mem[n])) * 65536) / mu);
    endfunction

    function automatic logic [31:0] field_value(longint j, longint s, logic [31:0] mu32);
        longint          p;
        logic            neg;
        longint unsigned mag, mu, q, r, h;
        p   = j * s;
        neg = p < 0;
        mag = neg ? longint'(-p) : longint'(p);
        mu  = longint'(mu32);
        q   = mag / mu;
        r   = mag % mu;
        if (q >= 4096)
            h = 64'h1_0000_0000;
        else
            h = (q * INV_MU0 + (r * INV_MU0) / mu) >> 8;
        if (neg)
            return (h >= 64'h8000_0000) ? 32'h8000_0000 : 32'(0 - h);
        return (h > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : h[31:0];
    endfunction

    function automatic field_result_t predict_field(logic [lefs_pkg::IDX_W-1:0] idx);
        field_result_t res;
        int unsigned   sx, sy, sz, sxy, x, y, z, rem, base, i;
        longint        mx, my, mz, dot;
        sx  = clamp_size(size_x, 32);
        sy  = clamp_size(size_y, 32);
        sz  = clamp_size(size_z, 16);
        sxy = sx * sy;
        i   = idx;
        res = '0;
        res.idx = idx;
        if (i < sxy * sz && moment_mem[i] != 0) begin
            z = i / sxy;
            rem = i % sxy;
            y = rem / sx;
            x = rem % sx;
            base = z * sxy + y * sx;
            nb_sum[0] = 0;
            nb_sum[1] = 0;
            nb_sum[2] = 0;
            if (x > 0) add_neighbor(i - 1);
            else if (wrap_x) add_neighbor(base + sx - 1);
            if (x + 1 < sx) add_neighbor(i + 1);
            else if (wrap_x) add_neighbor(base);
            if (y > 0) add_neighbor(i - sx);
            else if (wrap_y) add_neighbor(i + (sy - 1) * sx);
            if (y + 1 < sy) add_neighbor(i + sx);
            else if (wrap_y) add_neighbor(i - (sy - 1) * sx);
            if (z > 0) add_neighbor(i - sxy);
            else if (wrap_z) add_neighbor(i + (sz - 1) * sxy);
            if (z + 1 < sz) add_neighbor(i + sxy);
            else if (wrap_z) add_neighbor(i - (sz - 1) * sxy);
            res.hx = field_value(longint'(signed'(coupling_mem[i])), clip32(nb_sum[0]),
                                 moment_mem[i]);
            res.hy = field_value(longint'(signed'(coupling_mem[i])), clip32(nb_sum[1]),
                                 moment_mem[i]);
            res.hz = field_value(longint'(signed'(coupling_mem[i])), clip32(nb_sum[2]),
                                 moment_mem[i]);
            mx = longint'(signed'(magx_mem[i])) * longint'(signed'(res.hx));
            my = longint'(signed'(magy_mem[i])) * longint'(signed'(res.hy));
            mz = longint'(signed'(magz_mem[i])) * longint'(signed'(res.hz));
            dot = add_sat64(add_sat64(mx, my), mz);
            energy = add_sat64(energy, dot);
        end
        res.energy = energy;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        field_result_t want, got;
        int unsigned   li;
        if (!rst_n) begin
            energy  = 0;
            size_x  = 6'd32;
            size_y  = 6'd32;
            size_z  = 5'd16;
            wrap_x  = 1'b0;
            wrap_y  = 1'b0;
            wrap_z  = 1'b0;
            field_q.delete();
            errors  <= 0;
            pending <= 0;
            results <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    lefs_pkg::CFG_SIZE_X: size_x = cfg_data[5:0];
                    lefs_pkg::CFG_SIZE_Y: size_y = cfg_data[5:0];
                    lefs_pkg::CFG_SIZE_Z: size_z = cfg_data[4:0];
                    lefs_pkg::CFG_WRAP_X: wrap_x = cfg_data[0];
                    lefs_pkg::CFG_WRAP_Y: wrap_y = cfg_data[0];
                    lefs_pkg::CFG_WRAP_Z: wrap_z = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.idx    = m_tdata[13:0];
                got.hx     = m_tdata[45:14];
                got.hy     = m_tdata[77:46];
                got.hz     = m_tdata[109:78];
                got.energy = m_tdata[173:110];
                results <= results + 1;
                if (field_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    errors <= errors + 1;
                end else begin
                    want = field_q.pop_front();
                    if (got.idx !== want.idx || got.hx !== want.hx || got.hy !== want.hy ||
                        got.hz !== want.hz || got.energy !== want.energy) begin
                        $display("%0t: mismatch expected idx %0d h %h %h %h e %h", $time,
                                 want.idx, want.hx, want.hy, want.hz, want.energy);
                        $display("%0t:          actual   idx %0d h %h %h %h e %h", $time,
                                 got.idx, got.hx, got.hy, got.hz, got.energy);
                        errors <= errors + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                li = s_tdata[13:0];
                if (!s_tuser) begin
                    // a load clears the energy sum
                    energy = 0;
                    moment_mem[li]   = s_tdata[45:14];
                    coupling_mem[li] = s_tdata[77:46];
                    magx_mem[li]     = s_tdata[109:78];
                    magy_mem[li]     = s_tdata[141:110];
                    magz_mem[li]     = s_tdata[173:142];
                end else begin
                    field_q.push_back(predict_field(s_tdata[13:0]));
                end
            end
            pending <= field_q.size();
        end
    end

endmodule

FILE: verif/lattice_exchange_field_stencil_tb.sv
// ----------------------------------------------------------------------------
// lattice_exchange_field_stencil_tb
// Drives load and compute transactions over several lattice shapes and wrap
// settings with varying back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module lattice_exchange_field_stencil_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 30_000_000;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [lefs_pkg::TDATA_W-1:0]    s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [lefs_pkg::TDATA_W-1:0]    m_tdata;
    logic                            cfg_we;
    logic [lefs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lefs_pkg::CFG_DATA_W-1:0] cfg_data;
    int                              errors, pending, results;

    int          send_idle_pct, recv_stall_pct;
    logic        hold_req, hold_ack, hold_on;
    bit          written [16384];
    int unsigned lattice_cells;
    int          n_loads, n_computes;

    lattice_exchange_field_stencil dut (.*);

    lattice_exchange_field_stencil_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        longint cycles;
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end

    // long receiver hold-off, counted here
    initial
    begin
        hold_ack = 1'b0;
        hold_on  = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req != hold_ack) begin
                hold_ack <= hold_req;
                hold_on  <= 1'b1;
                repeat (5000) @(posedge clk);
                hold_on  <= 1'b0;
            end
        end
    end

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'(signed'($urandom_range(65536 * 4)) - 131072);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rnd_moment();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'(1 + $urandom_range(255));
            2: return 32'hFFFF_FFFF;
            3: return 32'(32'h0000_8000 + $urandom_range(32'h0004_0000));
            default: return $urandom();
        endcase
    endfunction

    task automatic send(input logic kind, input logic [lefs_pkg::IDX_W-1:0] idx,
                        input logic [31:0] mom, input logic [31:0] coup,
                        input logic [31:0] mx, input logic [31:0] my,
                        input logic [31:0] mz);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, mz, my, mx, coup, mom, idx};
        do
            @(posedge clk);
        while (!s_tready);
        if (kind)
            n_computes++;
        else begin
            n_loads++;
            written[idx] = 1'b1;
        end
    endtask

    task automatic load_cell(input logic [lefs_pkg::IDX_W-1:0] idx);
        send(1'b0, idx, rnd_moment(), rnd_word(), rnd_word(), rnd_word(), rnd_word());
    endtask

    task automatic compute_cell(input logic [lefs_pkg::IDX_W-1:0] idx);
        send(1'b1, idx, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        // let a trailing load settle
        repeat (50) @(posedge clk);
    endtask

    // write enable stays high across back-to-back writes, the caller drops it
    task automatic write_reg(input lefs_pkg::cfg_reg_t r,
                             input logic [lefs_pkg::CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
    endtask

    task automatic set_lattice(input int sx, input int sy, input int sz,
                               input bit wx, input bit wy, input bit wz);
        int unsigned ex, ey, ez;
        wait_idle();
        write_reg(lefs_pkg::CFG_SIZE_X, 6'(sx));
        write_reg(lefs_pkg::CFG_SIZE_Y, 6'(sy));
        write_reg(lefs_pkg::CFG_SIZE_Z, 6'(sz & 31));
        write_reg(lefs_pkg::CFG_WRAP_X, 6'(wx));
        write_reg(lefs_pkg::CFG_WRAP_Y, 6'(wy));
        write_reg(lefs_pkg::CFG_WRAP_Z, 6'(wz));
        cfg_we <= 1'b0;
        ex = (sx == 0) ? 1 : ((sx > 32) ? 32 : sx);
        ey = (sy == 0) ? 1 : ((sy > 32) ? 32 : sy);
        ez = ((sz & 31) == 0) ? 1 : (((sz & 31) > 16) ? 16 : (sz & 31));
        lattice_cells = ex * ey * ez;
        // every cell in use must hold data before any compute can read it
        for (int unsigned i = 0; i < lattice_cells; i++)
            if (!written[i])
                load_cell(i);
    endtask

    task automatic run_phase(input int sx, input int sy, input int sz, input bit wx,
                             input bit wy, input bit wz, input int items,
                             input int sidle, input int rstall, input bit hold);
        logic [lefs_pkg::IDX_W-1:0] idx;
        set_lattice(sx, sy, sz, wx, wy, wz);
        send_idle_pct  <= sidle;
        recv_stall_pct <= rstall;
        if (hold)
            hold_req <= ~hold_req;
        for (int k = 0; k < items; k++) begin
            if ($urandom_range(9) == 0)
                idx = $urandom_range(16383);
            else
                idx = $urandom_range(lattice_cells - 1);
            if ($urandom_range(99) < 40)
                compute_cell(idx);
            else
                load_cell(idx);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tuser        = 1'b0;
        s_tdata        = '0;
        cfg_we         = 1'b0;
        cfg_index      = lefs_pkg::CFG_SIZE_X;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        n_loads        = 0;
        n_computes     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 3x3x2 open lattice with saturating and empty cells
        set_lattice(3, 3, 2, 1'b0, 1'b0, 1'b0);
        send(1'b0, 14'd4, 32'h0001_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h0001_0000);
        send(1'b0, 14'd3, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
             32'hFFFF_FFFF);
        send(1'b0, 14'd5, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
             32'h8000_0000);
        send(1'b0, 14'd13, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000);
        send(1'b0, 14'd0, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
             32'h0001_0000);
        compute_cell(14'd4);
        compute_cell(14'd13);
        compute_cell(14'd0);
        compute_cell(14'd3);
        compute_cell(14'd5);
        compute_cell(14'd18);
        compute_cell(14'd16383);
        send(1'b0, 14'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000);
        compute_cell(14'd1);
        compute_cell(14'd17);
        compute_cell(14'd8);
        set_lattice(3, 3, 2, 1'b1, 1'b1, 1'b1);
        compute_cell(14'd0);
        compute_cell(14'd8);
        compute_cell(14'd17);
        compute_cell(14'd4);

        // random phases: shapes, wraps, clamped sizes and idling modes
        run_phase(3, 3, 2, 0, 0, 0, 200, 0, 0, 0);
        run_phase(4, 3, 2, 1, 1, 1, 200, 57, 0, 1);
        run_phase(2, 2, 2, 1, 1, 1, 150, 0, 57, 0);
        run_phase(1, 1, 1, 1, 1, 1, 100, 9, 9, 0);
        run_phase(0, 0, 31, 0, 1, 0, 60, 0, 0, 0);
        run_phase(63, 0, 1, 1, 0, 1, 120, 57, 0, 0);
        run_phase(32, 1, 2, 1, 0, 0, 150, 0, 57, 0);
        run_phase(5, 4, 3, 0, 1, 1, 200, 9, 9, 0);
        run_phase(3, 5, 4, 1, 0, 1, 200, 0, 0, 1);

        wait_idle();
        repeat (200) @(posedge clk);
        $display("summary: %0d loads, %0d computes, %0d results over nine lattice shapes",
                 n_loads, n_computes, results);
        $display("summary: open and periodic axes, clamped sizes, stalls and a long hold-off");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
